// ===== hdl/sha_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-256 package
// Shared types, constants and round functions of the stream hasher.
// ---------------------------------------------------------------------------
package sha_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = 2;

  typedef enum logic {
    ACT_ABSORB   = 1'b0,
    ACT_FINALIZE = 1'b1
  } action_e;

  // One classified word handed from the front end to the core.
  typedef struct packed {
    logic       finalize;
    logic [7:0] data;
  } cmd_t;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [7:0]  PAD_BYTE    = 8'h80;
  localparam logic [5:0]  LEN_OFFSET  = 6'd56;
  localparam logic [63:0] BLOCK_BITS  = 64'd512;

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] ssig0(input logic [31:0] x);
    ssig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] ssig1(input logic [31:0] x);
    ssig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] bsig0(input logic [31:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] bsig1(input logic [31:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage
`default_nettype wire

// ===== hdl/sha_cmd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// SHA command queue
// Front end: takes input words, classifies them and buffers them.
// ---------------------------------------------------------------------------
module sha_cmd_queue (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          valid_i,
  output logic               stall_o,
  input  wire logic          action_i,
  input  wire logic [7:0]    data_byte_i,
  output logic               cmd_valid_o,
  input  wire logic          cmd_pop_i,
  output sha_pkg::cmd_t      cmd_o
);
  import sha_pkg::*;

  cmd_t                 mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_q, rd_q;
  logic [QueuePtrW:0]   cnt_q;
  logic                 push, pop;

  assign stall_o     = (cnt_q == (QueuePtrW+1)'(QueueDepth)) ? 1'b1 : 1'b0;
  assign push        = valid_i && !stall_o;
  assign cmd_valid_o = (cnt_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q].finalize <= (action_e'(action_i) == ACT_FINALIZE);
      mem_q[wr_q].data     <= data_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= wr_q + 1'b1;
      if (pop)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (QueuePtrW+1)'(push) - (QueuePtrW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sha_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// SHA core
// Back end: block store, padding, one round per cycle, digest output.
// ---------------------------------------------------------------------------
module sha_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          cmd_valid_i,
  output logic               cmd_pop_o,
  input  wire sha_pkg::cmd_t cmd_i,
  output logic               valid_o,
  input  wire logic          stall_i,
  output logic [31:0]        digest_word_o,
  output logic [2:0]         word_index_o,
  output logic               last_word_o
);
  import sha_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_PAD, ST_ROUND, ST_FOLD, ST_EMIT
  } state_e;

  state_e       state_q;
  logic [31:0]  blk_q [16];  // block store, big-endian words
  logic [5:0]   fill_q;
  logic [63:0]  bits_q;
  logic [63:0]  total_q;
  logic         fin_q;       // finalize in progress
  logic         len_blk_q;   // block being padded is the one carrying length
  logic [5:0]   pos_q;
  logic [31:0]  h_q [8];
  logic [31:0]  v_q [8];
  logic [31:0]  w_q [16];
  logic [5:0]   rnd_q;
  logic [2:0]   out_idx_q;

  logic [31:0]  w_cur, w_new, t1, t2;

  // Replace one byte lane of a store word; lane 0 is the most significant.
  function automatic logic [31:0] put_byte(input logic [31:0] w, input logic [1:0] lane,
                                           input logic [7:0] b);
    logic [31:0] r;
    r = w;
    case (lane)
      2'd0:    r[31:24] = b;
      2'd1:    r[23:16] = b;
      2'd2:    r[15:8]  = b;
      default: r[7:0]   = b;
    endcase
    return r;
  endfunction

  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;

  // Message schedule: sliding 16-word window, w_q[0] is w[i].
  assign w_new = ssig1(w_q[14]) + w_q[9] + ssig0(w_q[1]) + w_q[0];
  assign w_cur = w_q[0];
  assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + ROUND_K[rnd_q] + w_cur;
  assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  assign valid_o       = (state_q == ST_EMIT);
  assign digest_word_o = h_q[out_idx_q];
  assign word_index_o  = out_idx_q;
  assign last_word_o   = (out_idx_q == 3'd7);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fill_q    <= '0;
      bits_q    <= '0;
      fin_q     <= 1'b0;
      len_blk_q <= 1'b0;
      rnd_q     <= '0;
      out_idx_q <= '0;
      pos_q     <= '0;
      total_q   <= '0;
      for (int i = 0; i < 8; i++) h_q[i] <= H_INIT[i];
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cmd_valid_i) begin
            if (!cmd_i.finalize) begin
              blk_q[fill_q[5:2]] <= put_byte(blk_q[fill_q[5:2]], fill_q[1:0], cmd_i.data);
              fill_q             <= fill_q + 1'b1;
              if (fill_q == 6'd63) begin
                bits_q  <= bits_q + BLOCK_BITS;
                fin_q   <= 1'b0;
                state_q <= ST_ROUND;
                rnd_q   <= '0;
                for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
                for (int j = 0; j < 15; j++) w_q[j] <= blk_q[j];
                w_q[15] <= {blk_q[15][31:8], cmd_i.data};
              end
            end else begin
              total_q            <= bits_q + {55'd0, fill_q, 3'd0};
              blk_q[fill_q[5:2]] <= put_byte(blk_q[fill_q[5:2]], fill_q[1:0], PAD_BYTE);
              pos_q              <= fill_q + 1'b1;
              len_blk_q          <= (fill_q < 6'd56);
              fin_q              <= 1'b1;
              state_q            <= ST_PAD;
            end
          end
        end
        // One zero byte per cycle up to the end of the block (or the length field).
        ST_PAD: begin
          if ((pos_q == '0 && !len_blk_q) || (len_blk_q && pos_q >= LEN_OFFSET)) begin
            // block complete: load the window; in the length block the length goes straight into words 14/15
            rnd_q <= '0;
            for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
            for (int j = 0; j < 14; j++) w_q[j] <= blk_q[j];
            if (len_blk_q) begin
              w_q[14] <= total_q[63:32];
              w_q[15] <= total_q[31:0];
            end else begin
              w_q[14] <= blk_q[14];
              w_q[15] <= blk_q[15];
            end
            state_q <= ST_ROUND;
          end else begin
            blk_q[pos_q[5:2]] <= put_byte(blk_q[pos_q[5:2]], pos_q[1:0], 8'h00);
            pos_q             <= pos_q + 1'b1;
          end
        end
        ST_ROUND: begin
          v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4]; v_q[4] <= v_q[3] + t1;
          v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0]; v_q[0] <= t1 + t2;
          for (int j = 0; j < 15; j++) w_q[j] <= w_q[j+1];
          w_q[15] <= w_new;
          rnd_q   <= rnd_q + 1'b1;
          if (rnd_q == 6'd63) state_q <= ST_FOLD;
        end
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          if (!fin_q) begin
            fill_q  <= '0;
            state_q <= ST_IDLE;
          end else if (!len_blk_q) begin
            len_blk_q <= 1'b1;
            pos_q     <= '0;
            state_q   <= ST_PAD;
          end else begin
            out_idx_q <= '0;
            state_q   <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (!stall_i) begin
            out_idx_q <= out_idx_q + 1'b1;
            if (out_idx_q == 3'd7) begin
              for (int i = 0; i < 8; i++) h_q[i] <= H_INIT[i];
              fill_q  <= '0;
              bits_q  <= '0;
              fin_q   <= 1'b0;
              state_q <= ST_IDLE;
            end
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== hdl/sha256_stream_hasher.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// SHA-256 stream hasher
// Streaming SHA-256: one message byte per input word, digest out as words.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (valid_i / stall_o): action_i = 0 absorbs data_byte_i,
//   action_i = 1 pads the message and starts digest output.
//   Output channel (valid_o / stall_i): eight 32-bit digest words, most
//   significant first, word_index_o 0..7, last_word_o on word 7.
//   A four-entry queue decouples input acceptance from the core.
// Timing:
//   The core takes a byte from the queue whenever it is idle; every 64th
//   byte adds a 64-round compression at one round per cycle plus a fold
//   step. Finalize costs padding (one zero byte per cycle) plus one or
//   two compressions, then the digest words go out in turn.
// Reset puts the initial hash values in place and empties the queue.
// A stalled receiver holds the current digest word; the queue keeps
// taking input until it is full. After the last word the core restarts.
// ---------------------------------------------------------------------------
module sha256_stream_hasher (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             stall_o,
  input  wire logic        action_i,
  input  wire logic [7:0]  data_byte_i,
  output logic             valid_o,
  input  wire logic        stall_i,
  output logic [31:0]      digest_word_o,
  output logic [2:0]       word_index_o,
  output logic             last_word_o
);
  import sha_pkg::*;

  cmd_t cmd;
  logic cmd_valid, cmd_pop;

  sha_cmd_queue u_queue (
    .clk_i, .rst_ni, .valid_i, .stall_o, .action_i, .data_byte_i,
    .cmd_valid_o(cmd_valid), .cmd_pop_i(cmd_pop), .cmd_o(cmd)
  );

  sha_core u_core (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_pop_o(cmd_pop), .cmd_i(cmd),
    .valid_o, .stall_i, .digest_word_o, .word_index_o, .last_word_o
  );

  // Word index steps by one per delivered word.
  a_idx_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !stall_i && !last_word_o) |=> (valid_o && word_index_o == $past(word_index_o) + 3'd1))
    else $error("digest word index skipped");

  // Last flag only on the eighth word.
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> (last_word_o == (word_index_o == 3'd7)))
    else $error("last_word misplaced");

  // A stalled digest word holds.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && stall_i) |=> (valid_o && $stable(digest_word_o)))
    else $error("digest word changed under stall");

endmodule
`default_nettype wire

// ===== sim/sha256_stream_hasher_tb.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// SHA-256 stream hasher testbench
// Streams byte and finalize words into the hasher, predicts each digest with
// a behavioral SHA-256 and checks every digest word as it leaves the block.
// ---------------------------------------------------------------------------
module sha256_stream_hasher_tb;
  import sha_pkg::*;

  typedef struct {
    action_e    act;
    logic [7:0] data;
  } in_word_t;

  typedef struct {
    logic [31:0] dword;
    logic [2:0]  idx;
    logic        last;
  } digest_exp_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        stall_o;
  logic        action_i = 1'b0;
  logic [7:0]  data_byte_i = 8'h00;
  logic        valid_o;
  logic        stall_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  sha256_stream_hasher u_top (
    .clk_i, .rst_ni, .valid_i, .stall_o, .action_i, .data_byte_i,
    .valid_o, .stall_i, .digest_word_o, .word_index_o, .last_word_o
  );

  always #6 clk_i = ~clk_i;

  // Round constants, kept locally so the predictor is independent.
  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [31:0] IV_TAB [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Predictor state: chaining words, pending block, fill level, length.
  logic [31:0] hash_h [8];
  logic [7:0]  blk [64];
  logic [5:0]  fill;
  logic [63:0] len_bits;

  in_word_t    pending_words[$];
  digest_exp_t digest_q[$];
  bit          mismatch = 1'b0;
  bit          stim_done = 1'b0;
  bit          quiet_phase = 1'b0;  // long stretch with no idling

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress_block();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    v = hash_h;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] += v[i];
  endtask

  task automatic clear_hash();
    hash_h = IV_TAB;
    fill = '0;
    len_bits = '0;
  endtask

  // Apply one accepted word; a finalize queues the eight digest words.
  task automatic predict_digest(in_word_t iw);
    logic [63:0] total;
    int pos;
    if (iw.act == ACT_ABSORB) begin
      blk[fill] = iw.data;
      fill++;
      if (fill == 0) begin
        compress_block();
        len_bits += 64'd512;
      end
    end else begin
      total = len_bits + 64'(fill) * 8;
      pos = fill;
      blk[pos] = 8'h80;
      pos++;
      // fewer than nine bytes of room: padding spills into an extra block
      if (pos > 56) begin
        while (pos < 64) begin blk[pos] = 8'h00; pos++; end
        compress_block();
        pos = 0;
      end
      while (pos < 56) begin blk[pos] = 8'h00; pos++; end
      for (int i = 0; i < 8; i++) blk[56+i] = total[63-8*i -: 8];
      compress_block();
      for (int i = 0; i < 8; i++)
        digest_q.push_back('{dword: hash_h[i], idx: 3'(i), last: (i == 7)});
      clear_hash();
    end
  endtask

  task automatic add_msg(int n, bit fixed, logic [7:0] val);
    for (int i = 0; i < n; i++)
      pending_words.push_back('{act: ACT_ABSORB,
                                data: fixed ? val : 8'($urandom_range(255))});
    pending_words.push_back('{act: ACT_FINALIZE, data: 8'($urandom_range(255))});
  endtask

  // Driver: present words from the pending queue, hold while stalled.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (!valid_i || !stall_o) begin
        if (pending_words.size() != 0 &&
            (quiet_phase || $urandom_range(99) >= 18)) begin
          valid_i     <= 1'b1;
          action_i    <= pending_words[0].act;
          data_byte_i <= pending_words[0].data;
          predict_digest(pending_words.pop_front());
        end else begin
          valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: check accepted digest words against the expected digest.
  always @(posedge clk_i) begin
    digest_exp_t e;
    if (rst_ni) begin
      if (valid_o && !stall_i) begin
        if (digest_q.size() == 0) begin
          $display("%0t: unexpected digest word: expected none, actual %h idx %0d last %0b",
                   $time, digest_word_o, word_index_o, last_word_o);
          mismatch = 1'b1;
        end else begin
          e = digest_q.pop_front();
          if (digest_word_o !== e.dword || word_index_o !== e.idx ||
              last_word_o !== e.last) begin
            $display("%0t: digest word: expected %h idx %0d last %0b, actual %h idx %0d last %0b",
                     $time, e.dword, e.idx, e.last, digest_word_o, word_index_o,
                     last_word_o);
            mismatch = 1'b1;
          end
        end
      end
      stall_i <= quiet_phase ? 1'b0 : ($urandom_range(99) < 18);
    end
  end

  initial begin
    int sent;
    clear_hash();
    for (int i = 0; i < 64; i++) blk[i] = 8'h00;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty message, byte extremes, short messages.
    add_msg(0, 1, 8'h00);
    add_msg(1, 1, 8'h00);
    add_msg(1, 1, 8'hff);
    add_msg(3, 1, 8'h55);   // short message, bits alternate
    add_msg(3, 1, 8'haa);
    add_msg(7, 0, 8'h00);
    // finalize back to back: an empty message right after a finalize
    add_msg(0, 1, 8'h00);
    // Sender idles until every digest word is out.
    while (pending_words.size() != 0 || digest_q.size() != 0) @(posedge clk_i);

    // Padding boundaries, run with no idling on either side.
    quiet_phase = 1'b1;
    add_msg(55, 0, 8'h00);  // padding just fits one block
    add_msg(56, 0, 8'h00);  // padding spills into a second block
    add_msg(63, 0, 8'h00);
    add_msg(64, 0, 8'h00);  // full block, then padding-only block
    while (pending_words.size() != 0 || digest_q.size() != 0) @(posedge clk_i);
    quiet_phase = 1'b0;

    // Random messages: mostly short, a few past one block.
    sent = 0;
    while (sent < 66) begin
      int n;
      n = ($urandom_range(9) == 0) ? $urandom_range(70) : $urandom_range(12);
      add_msg(n, 0, 8'h00);
      sent += n + 1;
      while (pending_words.size() > 40) @(posedge clk_i);
    end
    quiet_phase = 1'b0;
    while (pending_words.size() != 0 || valid_i) @(posedge clk_i);
    stim_done = 1'b1;
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (!mismatch) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end
endmodule

// ===== filelist.f =====
hdl/sha_pkg.sv
hdl/sha_cmd_queue.sv
hdl/sha_core.sv
hdl/sha256_stream_hasher.sv
sim/sha256_stream_hasher_tb.sv
